// ===== hdl/rrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_pkg: constants for the range random generator
// Minimal-standard generator constants and the datapath widths they set.
// ----------------------------------------------------------------------------
package rrg_pkg;

    localparam int STATE_W  = 31;                 // generator state width
    localparam int MULT_W   = 15;                 // multiplier constant width
    localparam int PROD_W   = STATE_W + MULT_W;   // full product width
    localparam int WORD_W   = 32;                 // range bound / result width

    typedef logic [STATE_W-1:0] gen_state_t;
    typedef logic [WORD_W-1:0]  word_t;

    localparam logic [MULT_W-1:0]  MULTIPLIER = 15'd16807;
    localparam logic [STATE_W-1:0] MODULUS    = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] ZERO_SUBST = 31'd123459876;
    localparam logic [STATE_W-1:0] RESET_SEED = 31'd1;

endpackage

// ===== hdl/range_random_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_random_generator: minimal-standard random number in a signed range
// Advances 16807*x mod (2^31-1) and reduces the new state modulo the span.
// ----------------------------------------------------------------------------
// A non-empty range runs multiply, fold, reduce, 31 restoring division
// steps and the output load; an empty range goes straight to the output
// load. One word is in flight at a time: a new word is accepted only once
// the last result is loaded, which a result stall can hold off. The
// one-bit-per-cycle remainder loop on the shared subtractor sets the pace.
// Reset: rst_n async active low; generator state returns to 1, output empty.
module range_random_generator
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: seed write
    input  logic        seed_we,
    input  logic [30:0] seed_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] range_low, [63:32] range_high
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_value
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_FOLD   = 3'd2;
    localparam logic [2:0] ST_REDUCE = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    localparam int W     = rrg_pkg::WORD_W;
    localparam int SW    = rrg_pkg::STATE_W;
    localparam int PW    = rrg_pkg::PROD_W;
    localparam int CNT_W = $clog2(SW);

    logic [2:0]              state_reg, state_next;
    rrg_pkg::gen_state_t     gen_reg, gen_next;
    logic                    m_valid_reg, m_valid_next;
    rrg_pkg::word_t          m_data_reg, m_data_next;
    rrg_pkg::word_t          lo_reg, lo_next;
    rrg_pkg::word_t          span_reg, span_next;
    rrg_pkg::word_t          rem_reg, rem_next;
    rrg_pkg::gen_state_t     quo_reg, quo_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [W-1:0]            acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // shared subtractor
    logic [W:0]              sub_a, sub_b, sub_diff;
    logic                    sub_borrow;

    rrg_pkg::word_t          in_lo, in_hi;
    rrg_pkg::gen_state_t     gen_eff;
    logic [W:0]              partial;

    assign in_lo = s_tdata[W-1:0];
    assign in_hi = s_tdata[2*W-1:W];

    // zero state is replaced before advancing
    assign gen_eff = (gen_reg == '0) ? rrg_pkg::ZERO_SUBST : gen_reg;

    // next partial remainder: shift in one dividend bit
    assign partial = {rem_reg, quo_reg[SW-1]};

    // operand select for the one subtractor
    always_comb
    begin
        if (state_reg == ST_REDUCE)
        begin
            sub_a = {1'b0, acc_reg};
            sub_b = {2'b00, rrg_pkg::MODULUS};
        end
        else
        begin
            sub_a = partial;
            sub_b = {1'b0, span_reg};
        end
    end

    assign sub_diff   = sub_a - sub_b;
    assign sub_borrow = sub_diff[W];

    // sequencer and datapath
    always_comb
    begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        lo_next      = lo_reg;
        span_next    = span_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    lo_next   = in_lo;
                    span_next = in_hi - in_lo;
                    rem_next  = '0;
                    // empty range: return low, state untouched
                    if ($signed(in_lo) >= $signed(in_hi))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = gen_eff * rrg_pkg::MULTIPLIER;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                // 2^31 == 1 mod M: add high part onto low part
                acc_next   = W'(prod_reg[PW-1:SW]) + W'(prod_reg[SW-1:0]);
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // one conditional subtract of M finishes the reduction
                if (sub_borrow)
                begin
                    gen_next = acc_reg[SW-1:0];
                end
                else
                begin
                    gen_next = sub_diff[SW-1:0];
                end
                quo_next   = gen_next;
                rem_next   = '0;
                cnt_next   = CNT_W'(SW - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division step, remainder only
                if (sub_borrow)
                begin
                    rem_next = partial[W-1:0];
                end
                else
                begin
                    rem_next = sub_diff[W-1:0];
                end
                quo_next = {quo_reg[SW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = lo_reg + rem_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // nonzero seed reloads the state
        if (seed_we && (seed_data != '0))
        begin
            gen_next = seed_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            gen_reg     <= rrg_pkg::RESET_SEED;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        lo_reg     <= lo_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // remainder is always reduced below the span before it is added
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> ((rem_reg == '0) || (rem_reg < span_reg)))
        else $error("remainder not below span");

    // reduction leaves the state strictly below the modulus
    a_state_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_REDUCE) && !(seed_we && (seed_data != '0)))
        |=> (gen_reg < rrg_pkg::MODULUS))
        else $error("generator state not reduced");

    // a new result appears only out of the finish step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside finish step");
`endif

endmodule
